### hdl/lvtc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the literal value type classifier.
// No dependencies; used by literal_value_type_classifier_top.
package lvtc_pkg;

    // parse phases
    localparam logic [3:0] PH_START  = 4'd0;
    localparam logic [3:0] PH_SIGNED = 4'd1;
    localparam logic [3:0] PH_ZERO   = 4'd2;
    localparam logic [3:0] PH_DEC    = 4'd3;
    localparam logic [3:0] PH_BIN    = 4'd4;
    localparam logic [3:0] PH_OCT    = 4'd5;
    localparam logic [3:0] PH_HEX    = 4'd6;
    localparam logic [3:0] PH_FRAC   = 4'd7;
    localparam logic [3:0] PH_EXP0   = 4'd8;
    localparam logic [3:0] PH_EXPS   = 4'd9;
    localparam logic [3:0] PH_EXP    = 4'd10;
    localparam logic [3:0] PH_WORD   = 4'd11;
    localparam logic [3:0] PH_BAD    = 4'd12;

    // digit comparison against a threshold
    localparam logic [1:0] ORD_EQ = 2'd0;
    localparam logic [1:0] ORD_LT = 2'd1;
    localparam logic [1:0] ORD_GT = 2'd2;

    // result codes
    localparam logic [4:0] T_INVALID = 5'd0;
    localparam logic [4:0] T_NULL    = 5'd1;
    localparam logic [4:0] T_BOOL    = 5'd2;
    localparam logic [4:0] T_UINT7   = 5'd3;
    localparam logic [4:0] T_BIGINT  = 5'd15;
    localparam logic [4:0] T_FLOAT   = 5'd16;

    localparam int NUM_THR = 12;
    localparam logic [6:0] DT_MAX = 7'd127;
    localparam logic [3:0] POS_MAX = 4'd15;

    typedef struct packed {
        logic [6:0] n;
        logic [3:0] lead;
        logic [4:0] vtype;
    } pow2_t;

    // decimal thresholds, BCD, first digit in the top nibble
    localparam logic [79:0] DEC_THR [NUM_THR] = '{
        {12'h127, 68'h0},
        {12'h255, 68'h0},
        {20'h32767, 60'h0},
        {20'h65535, 60'h0},
        {40'h2147483647, 40'h0},
        {40'h4294967295, 40'h0},
        {76'h9223372036854775807, 4'h0},
        80'h18446744073709551615,
        {12'h128, 68'h0},
        {20'h32768, 60'h0},
        {40'h2147483648, 40'h0},
        {76'h9223372036854775808, 4'h0}
    };
    localparam logic [6:0] DEC_LEN [NUM_THR] = '{
        7'd3, 7'd3, 7'd5, 7'd5, 7'd10, 7'd10, 7'd19, 7'd20, 7'd3, 7'd5, 7'd10, 7'd19
    };
    localparam logic [4:0] DEC_TYPE [NUM_THR] = '{
        5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14
    };

    // rows: binary, octal, hex
    localparam pow2_t POS_TAB [3][8] = '{
        '{'{7'd7,4'd1,5'd3}, '{7'd8,4'd1,5'd4}, '{7'd15,4'd1,5'd5}, '{7'd16,4'd1,5'd6},
          '{7'd31,4'd1,5'd7}, '{7'd32,4'd1,5'd8}, '{7'd63,4'd1,5'd9}, '{7'd64,4'd1,5'd10}},
        '{'{7'd3,4'd1,5'd3}, '{7'd3,4'd3,5'd4}, '{7'd5,4'd7,5'd5}, '{7'd6,4'd1,5'd6},
          '{7'd11,4'd1,5'd7}, '{7'd11,4'd3,5'd8}, '{7'd21,4'd7,5'd9}, '{7'd22,4'd1,5'd10}},
        '{'{7'd2,4'd7,5'd3}, '{7'd2,4'd15,5'd4}, '{7'd4,4'd7,5'd5}, '{7'd4,4'd15,5'd6},
          '{7'd8,4'd7,5'd7}, '{7'd8,4'd15,5'd8}, '{7'd16,4'd7,5'd9}, '{7'd16,4'd15,5'd10}}
    };
    localparam pow2_t NEG_TAB [3][4] = '{
        '{'{7'd8,4'd1,5'd11}, '{7'd16,4'd1,5'd12}, '{7'd32,4'd1,5'd13}, '{7'd64,4'd1,5'd14}},
        '{'{7'd3,4'd2,5'd11}, '{7'd6,4'd1,5'd12}, '{7'd11,4'd2,5'd13}, '{7'd22,4'd1,5'd14}},
        '{'{7'd2,4'd8,5'd11}, '{7'd4,4'd8,5'd12}, '{7'd8,4'd8,5'd13}, '{7'd16,4'd8,5'd14}}
    };

    // keywords, first character in the top byte
    localparam logic [63:0] KW_TEXT [5] = '{
        "Infinity", {"NaN", 40'h0}, {"true", 32'h0}, {"null", 32'h0}, {"false", 24'h0}
    };
    localparam logic [3:0] KW_LEN [5] = '{4'd8, 4'd3, 4'd4, 4'd4, 4'd5};

    function automatic logic [3:0] thr_digit(input logic [79:0] thr, input logic [4:0] k);
        logic [79:0] sh;
        begin
            sh = thr << {k, 2'b00};
            return sh[79:76];
        end
    endfunction

    function automatic logic [7:0] kw_char(input logic [63:0] kw, input logic [2:0] p);
        logic [63:0] sh;
        begin
            sh = kw << {p, 3'b000};
            return sh[63:56];
        end
    endfunction

endpackage

### hdl/literal_value_type_classifier_top.sv
`timescale 1ns / 1ps
// Literal value type classifier: character-serial parser and type coder.
// Depends on lvtc_pkg.
//
// Characters of a literal enter one per cycle (one transfer per cycle when
// the result side is not stalled). Each transfer lands in an input register;
// from it the parse state is updated, or reset after an item with last set
// or with has_char low, and such an item also writes the type code to the
// result register, whose valid flag is registered with it. The rate is one
// item per cycle, set by the single parse-state update; both sides stall
// only while a finished result waits to be taken.
module literal_value_type_classifier_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [7:0] ch,
    input  logic       has_char,
    input  logic       last,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [4:0] value_type
);

    logic       adv;
    logic       iv_reg;
    logic [7:0] ich_reg;
    logic       ihas_reg;
    logic       ilast_reg;
    logic       rv_reg;
    logic [4:0] type_reg;

    logic [3:0] phase_reg, phase_next;
    logic       neg_reg, neg_next;
    logic       sign_reg, sign_next;
    logic [6:0] dtot_reg, dtot_next;
    logic [3:0] lead_reg, lead_next;
    logic       rzero_reg, rzero_next;
    logic       pu_reg, pu_next;
    logic [3:0] pos_reg, pos_next;
    logic [4:0] wm_reg, wm_next;
    logic [1:0] ord_reg [lvtc_pkg::NUM_THR];
    logic [1:0] ord_next [lvtc_pkg::NUM_THR];

    logic       is_end;
    logic [4:0] fin;

    assign adv        = !(rv_reg && result_stall);
    assign item_stall = !adv;
    assign is_end     = iv_reg && (!ihas_reg || ilast_reg);

    // parse one character
    always_comb
    begin
        logic [7:0] c;
        logic       isdec;
        logic [3:0] d;
        logic       hok;
        logic [3:0] hv;
        logic       run_dec;
        logic       run_exp;
        logic       run_word;
        logic [4:0] k;
        c = ich_reg;
        isdec = (c >= "0") && (c <= "9");
        d = c[3:0];
        hok = 1'b0;
        hv = 4'd0;
        run_dec = 1'b0;
        run_exp = 1'b0;
        run_word = 1'b0;
        k = 5'd0;
        if (isdec)
        begin
            hok = 1'b1;
            hv = d;
        end
        else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
        begin
            hok = 1'b1;
            hv = c[3:0] + 4'd9;
        end

        phase_next = phase_reg;
        neg_next   = neg_reg;
        sign_next  = sign_reg;
        dtot_next  = dtot_reg;
        lead_next  = lead_reg;
        rzero_next = rzero_reg;
        pu_next    = pu_reg;
        pos_next   = pos_reg;
        wm_next    = wm_reg;
        for (int t = 0; t < lvtc_pkg::NUM_THR; t++)
        begin
            ord_next[t] = ord_reg[t];
        end

        if (ihas_reg)
        begin
            case (phase_reg)
                lvtc_pkg::PH_START, lvtc_pkg::PH_SIGNED:
                begin
                    if (phase_reg == lvtc_pkg::PH_START && (c == "+" || c == "-"))
                    begin
                        sign_next  = 1'b1;
                        neg_next   = (c == "-");
                        phase_next = lvtc_pkg::PH_SIGNED;
                    end
                    else if (c == "0")
                    begin
                        phase_next = lvtc_pkg::PH_ZERO;
                    end
                    else if (isdec)
                    begin
                        phase_next = lvtc_pkg::PH_DEC;
                        pos_next = 4'd0;
                        pu_next = 1'b0;
                        run_dec = 1'b1;
                    end
                    else
                    begin
                        phase_next = lvtc_pkg::PH_WORD;
                        run_word = 1'b1;
                    end
                end
                lvtc_pkg::PH_ZERO:
                begin
                    pos_next = 4'd0;
                    pu_next = 1'b0;
                    if (c == "b" || c == "B")
                        phase_next = lvtc_pkg::PH_BIN;
                    else if (c == "o" || c == "O")
                        phase_next = lvtc_pkg::PH_OCT;
                    else if (c == "x" || c == "X")
                        phase_next = lvtc_pkg::PH_HEX;
                    else if (c == ".")
                        phase_next = lvtc_pkg::PH_FRAC;
                    else if (c == "e" || c == "E")
                        phase_next = lvtc_pkg::PH_EXP0;
                    else
                    begin
                        phase_next = lvtc_pkg::PH_DEC;
                        run_dec = 1'b1;
                    end
                end
                lvtc_pkg::PH_DEC:
                begin
                    run_dec = 1'b1;
                end
                lvtc_pkg::PH_BIN, lvtc_pkg::PH_OCT, lvtc_pkg::PH_HEX:
                begin
                    if (phase_reg == lvtc_pkg::PH_BIN && hv > 4'd1)
                        hok = 1'b0;
                    if (phase_reg == lvtc_pkg::PH_OCT && hv > 4'd7)
                        hok = 1'b0;
                    if (hok)
                    begin
                        if (lead_reg == 4'd0 && hv != 4'd0)
                        begin
                            lead_next = hv;
                            dtot_next = 7'd1;
                        end
                        else if (lead_reg != 4'd0)
                        begin
                            if (dtot_reg < lvtc_pkg::DT_MAX)
                                dtot_next = dtot_reg + 7'd1;
                            if (hv != 4'd0)
                                rzero_next = 1'b0;
                        end
                        pu_next = 1'b0;
                        if (pos_reg < lvtc_pkg::POS_MAX)
                            pos_next = pos_reg + 4'd1;
                    end
                    else if (c == "_")
                    begin
                        if (pos_reg != 4'd0 && !pu_reg)
                        begin
                            pu_next = 1'b1;
                            if (pos_reg < lvtc_pkg::POS_MAX)
                                pos_next = pos_reg + 4'd1;
                        end
                        else
                            phase_next = lvtc_pkg::PH_BAD;
                    end
                    else
                        phase_next = lvtc_pkg::PH_BAD;
                end
                lvtc_pkg::PH_FRAC:
                begin
                    if ((c == "e" || c == "E") && !pu_reg)
                    begin
                        phase_next = lvtc_pkg::PH_EXP0;
                        pos_next = 4'd0;
                        pu_next = 1'b0;
                    end
                    else
                        run_exp = 1'b1;
                end
                lvtc_pkg::PH_EXP0, lvtc_pkg::PH_EXPS:
                begin
                    if (phase_reg == lvtc_pkg::PH_EXP0 && (c == "+" || c == "-"))
                        phase_next = lvtc_pkg::PH_EXPS;
                    else
                    begin
                        phase_next = lvtc_pkg::PH_EXP;
                        pos_next = 4'd0;
                        pu_next = 1'b0;
                        run_exp = 1'b1;
                    end
                end
                lvtc_pkg::PH_EXP:
                begin
                    run_exp = 1'b1;
                end
                lvtc_pkg::PH_WORD:
                begin
                    run_word = 1'b1;
                end
                default:
                begin
                    phase_next = lvtc_pkg::PH_BAD;
                end
            endcase
        end

        // digit-run body shared by fraction and exponent
        if (run_exp)
        begin
            if (isdec)
            begin
                pu_next = 1'b0;
                if (pos_next < lvtc_pkg::POS_MAX)
                    pos_next = pos_next + 4'd1;
            end
            else if (c == "_" && pos_next != 4'd0 && !pu_next)
            begin
                pu_next = 1'b1;
                if (pos_next < lvtc_pkg::POS_MAX)
                    pos_next = pos_next + 4'd1;
            end
            else
                phase_next = lvtc_pkg::PH_BAD;
        end

        if (run_dec)
        begin
            if (isdec)
            begin
                if (lead_next != 4'd0 || d != 4'd0)
                begin
                    k = dtot_next[4:0];
                    if (lead_next == 4'd0)
                        lead_next = d;
                    for (int t = 0; t < lvtc_pkg::NUM_THR; t++)
                    begin
                        if (dtot_next < lvtc_pkg::DEC_LEN[t] && ord_next[t] == lvtc_pkg::ORD_EQ)
                        begin
                            if (d < lvtc_pkg::thr_digit(lvtc_pkg::DEC_THR[t], k))
                                ord_next[t] = lvtc_pkg::ORD_LT;
                            else if (d > lvtc_pkg::thr_digit(lvtc_pkg::DEC_THR[t], k))
                                ord_next[t] = lvtc_pkg::ORD_GT;
                        end
                    end
                    if (dtot_next < lvtc_pkg::DT_MAX)
                        dtot_next = dtot_next + 7'd1;
                end
                pu_next = 1'b0;
                if (pos_next < lvtc_pkg::POS_MAX)
                    pos_next = pos_next + 4'd1;
            end
            else if (c == "_")
            begin
                if (pos_next != 4'd0 && !pu_next)
                begin
                    pu_next = 1'b1;
                    if (pos_next < lvtc_pkg::POS_MAX)
                        pos_next = pos_next + 4'd1;
                end
                else
                    phase_next = lvtc_pkg::PH_BAD;
            end
            else if ((c == "." || c == "e" || c == "E") && lead_next != 4'd0 && !pu_next)
            begin
                phase_next = (c == ".") ? lvtc_pkg::PH_FRAC : lvtc_pkg::PH_EXP0;
                pos_next = 4'd0;
                pu_next = 1'b0;
            end
            else
                phase_next = lvtc_pkg::PH_BAD;
        end

        if (run_word)
        begin
            for (int w = 0; w < 5; w++)
            begin
                if (pos_next >= lvtc_pkg::KW_LEN[w] ||
                    lvtc_pkg::kw_char(lvtc_pkg::KW_TEXT[w], pos_next[2:0]) != c)
                    wm_next[w] = 1'b0;
            end
            if (pos_next < lvtc_pkg::POS_MAX)
                pos_next = pos_next + 4'd1;
        end
    end

    // type code from the updated state
    always_comb
    begin
        logic         found;
        logic [1:0]   r;
        lvtc_pkg::pow2_t ent;
        found = 1'b0;
        r = 2'd0;
        ent = '0;
        fin = lvtc_pkg::T_INVALID;
        case (phase_next)
            lvtc_pkg::PH_ZERO:
                fin = lvtc_pkg::T_UINT7;
            lvtc_pkg::PH_DEC:
            begin
                if (pu_next)
                    fin = lvtc_pkg::T_INVALID;
                else if (lead_next == 4'd0)
                    fin = lvtc_pkg::T_UINT7;
                else
                begin
                    fin = lvtc_pkg::T_BIGINT;
                    if (neg_next)
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            if (!found &&
                                (dtot_next < lvtc_pkg::DEC_LEN[i + 8] ||
                                 (dtot_next == lvtc_pkg::DEC_LEN[i + 8] &&
                                  ord_next[i + 8] != lvtc_pkg::ORD_GT)))
                            begin
                                found = 1'b1;
                                fin = lvtc_pkg::DEC_TYPE[i + 8];
                            end
                        end
                    end
                    else
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            if (!found &&
                                (dtot_next < lvtc_pkg::DEC_LEN[i] ||
                                 (dtot_next == lvtc_pkg::DEC_LEN[i] &&
                                  ord_next[i] != lvtc_pkg::ORD_GT)))
                            begin
                                found = 1'b1;
                                fin = lvtc_pkg::DEC_TYPE[i];
                            end
                        end
                    end
                end
            end
            lvtc_pkg::PH_BIN, lvtc_pkg::PH_OCT, lvtc_pkg::PH_HEX:
            begin
                if (pos_next == 4'd0 || pu_next)
                    fin = lvtc_pkg::T_INVALID;
                else
                begin
                    r = 2'(phase_next - lvtc_pkg::PH_BIN);
                    fin = lvtc_pkg::T_BIGINT;
                    for (int i = 0; i < 8; i++)
                    begin
                        ent = neg_next ? lvtc_pkg::NEG_TAB[r][i % 4] : lvtc_pkg::POS_TAB[r][i];
                        if (!found && (!neg_next || i < 4))
                        begin
                            if (dtot_next < ent.n ||
                                (dtot_next == ent.n && (lead_next < ent.lead ||
                                 (lead_next == ent.lead && (!neg_next || rzero_next)))))
                            begin
                                found = 1'b1;
                                fin = ent.vtype;
                            end
                        end
                    end
                end
            end
            lvtc_pkg::PH_FRAC, lvtc_pkg::PH_EXP:
                fin = pu_next ? lvtc_pkg::T_INVALID : lvtc_pkg::T_FLOAT;
            lvtc_pkg::PH_WORD:
            begin
                if (wm_next[0] && pos_next == lvtc_pkg::KW_LEN[0])
                    fin = lvtc_pkg::T_FLOAT;
                else if (sign_next)
                    fin = lvtc_pkg::T_INVALID;
                else if (wm_next[1] && pos_next == lvtc_pkg::KW_LEN[1])
                    fin = lvtc_pkg::T_FLOAT;
                else if (wm_next[2] && pos_next == lvtc_pkg::KW_LEN[2])
                    fin = lvtc_pkg::T_BOOL;
                else if (wm_next[3] && pos_next == lvtc_pkg::KW_LEN[3])
                    fin = lvtc_pkg::T_NULL;
                else if (wm_next[4] && pos_next == lvtc_pkg::KW_LEN[4])
                    fin = lvtc_pkg::T_BOOL;
                else
                    fin = lvtc_pkg::T_INVALID;
            end
            default:
                fin = lvtc_pkg::T_INVALID;
        endcase
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg <= 1'b0;
        end
        else if (adv)
        begin
            iv_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && item_valid)
        begin
            ich_reg   <= ch;
            ihas_reg  <= has_char;
            ilast_reg <= last;
        end
    end

    // parse state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= lvtc_pkg::PH_START;
            neg_reg   <= 1'b0;
            sign_reg  <= 1'b0;
            dtot_reg  <= 7'd0;
            lead_reg  <= 4'd0;
            rzero_reg <= 1'b1;
            pu_reg    <= 1'b0;
            pos_reg   <= 4'd0;
            wm_reg    <= 5'h1F;
            for (int t = 0; t < lvtc_pkg::NUM_THR; t++)
            begin
                ord_reg[t] <= lvtc_pkg::ORD_EQ;
            end
            rv_reg    <= 1'b0;
        end
        else if (adv)
        begin
            rv_reg <= is_end;
            if (is_end)
            begin
                phase_reg <= lvtc_pkg::PH_START;
                neg_reg   <= 1'b0;
                sign_reg  <= 1'b0;
                dtot_reg  <= 7'd0;
                lead_reg  <= 4'd0;
                rzero_reg <= 1'b1;
                pu_reg    <= 1'b0;
                pos_reg   <= 4'd0;
                wm_reg    <= 5'h1F;
                for (int t = 0; t < lvtc_pkg::NUM_THR; t++)
                begin
                    ord_reg[t] <= lvtc_pkg::ORD_EQ;
                end
            end
            else if (iv_reg)
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                sign_reg  <= sign_next;
                dtot_reg  <= dtot_next;
                lead_reg  <= lead_next;
                rzero_reg <= rzero_next;
                pu_reg    <= pu_next;
                pos_reg   <= pos_next;
                wm_reg    <= wm_next;
                for (int t = 0; t < lvtc_pkg::NUM_THR; t++)
                begin
                    ord_reg[t] <= ord_next[t];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && is_end)
        begin
            type_reg <= fin;
        end
    end

    assign result_valid = rv_reg;
    assign value_type   = type_reg;

endmodule
